[rtl/lbsp_pkg.sv]
package lbsp_pkg;

  // field widths
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 4;
  localparam int DUR_W    = 16;
  localparam int BRI_W    = 7;
  localparam int TIME_W   = 24;
  localparam int SPEED_W  = 10;
  localparam int LEVEL_W  = 8;
  localparam int STEP_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  // duration scaling: dur * speed is 26 bits, /100 done as (x >> 2) / 25
  localparam int PROD_W      = DUR_W + SPEED_W;
  localparam int SCALED_W    = 20;
  localparam int MUL_A_W     = PROD_W - 2;
  localparam int MUL_B_W     = 25;
  localparam int RECIP_SHIFT = 29;
  localparam int RECIP_25    = ((2 ** RECIP_SHIFT) + 24) / 25;

  localparam int PCT_FULL   = 100;
  localparam logic [BRI_W-1:0] BRI_FULL = BRI_W'(PCT_FULL);
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam int SCRIPT_DEPTH_DEF = 16;
  localparam int LEVEL_MAX_DEF    = 255;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 3'd0,
    CMD_START  = 3'd1,
    CMD_PAUSE  = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_TICK   = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED  = 2'd0,
    REG_LOOP   = 2'd1,
    REG_ANALOG = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  entry_index;
    logic [DUR_W-1:0]  entry_duration;
    logic [BRI_W-1:0]  entry_brightness;
    logic              entry_is_end;
    logic [TIME_W-1:0] start_time;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] drive_level;
    logic               playing;
    logic [STEP_W-1:0]  step_index;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] wdata;
  } cfg_t;

  // one script table slot
  typedef struct packed {
    logic             is_end;
    logic [BRI_W-1:0] bri;
    logic [DUR_W-1:0] dur;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic [DUR_W-1:0]   duration;
    logic [SPEED_W-1:0] speed;
  } scl_req_t;

  typedef struct packed {
    logic                done;
    logic [SCALED_W-1:0] scaled;
  } scl_rsp_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/lbsp_if.sv]
interface lbsp_req_if;
  logic              valid;
  logic              ready;
  lbsp_pkg::req_t    payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface lbsp_rsp_if;
  logic              valid;
  logic              ready;
  lbsp_pkg::rsp_t    payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface lbsp_cfg_if;
  logic              valid;
  logic              ready;
  lbsp_pkg::cfg_t    payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

[rtl/led_brightness_script_player_core.sv]
// write, pause, resume, clear and no-op commands go from idle straight to the done state and the result beat
// start reads and scales each entry up to the end mark, then takes the offset modulo the total unless it is zero
// tick walks the entries up to the one reached, after a modulo when play time wraps
// one command at a time; each table entry passes the read, go and wait states on the shared multiplier
// the result beat sits in an output register, so the next command is taken while it waits
// rst is synchronous: control and player registers at power-on values, payload registers and script table undefined
module led_brightness_script_player_core #(
  parameter int SCRIPT_DEPTH = lbsp_pkg::SCRIPT_DEPTH_DEF,
  parameter int LEVEL_MAX    = lbsp_pkg::LEVEL_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lbsp_req_if.sink   req,
  lbsp_rsp_if.source rsp,
  lbsp_cfg_if.sink   cfg
);
  import lbsp_pkg::*;

  localparam int AW = $clog2(SCRIPT_DEPTH);
  localparam int CW = $clog2(SCRIPT_DEPTH + 1);
  localparam logic [LEVEL_W-1:0] LEVEL_LOW = LEVEL_W'(LEVEL_MAX % 256);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_GO   = 6'b000100,
    ST_WAIT = 6'b001000,
    ST_MOD  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  // sequencer and command capture
  state_t            state, state_next;
  logic [CMD_W-1:0]  cmd_q, cmd_q_next;
  logic [TIME_W-1:0] st_q, st_q_next;
  logic [CW-1:0]     i_cnt, i_cnt_next, i_inc;
  // running sum while measuring, remaining time while walking
  logic [TIME_W-1:0] t_acc, t_acc_next;

  // configuration registers
  logic [SPEED_W-1:0] speed, speed_next;
  logic               loop_en, loop_en_next;
  logic               analog, analog_next;

  // player state
  logic               loaded, loaded_next;
  logic [TIME_W-1:0]  play_time, play_time_next;
  logic [TIME_W-1:0]  paused_time, paused_time_next;
  logic [TIME_W-1:0]  total_time, total_time_next;
  logic               running, running_next;
  logic [LEVEL_W-1:0] level, level_next;
  logic [STEP_W-1:0]  step, step_next;

  // result register
  rsp_t out_q;
  logic out_valid, out_valid_next;
  logic load_out;

  // datapath hookups
  logic         req_ready;
  logic         mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  entry_t       mem_wdata, mem_rdata;
  scl_req_t     scl_req;
  scl_rsp_t     scl_rsp;
  div_req_t     div_req;
  div_rsp_t     div_rsp;

  logic [TIME_W:0]    sum_ext;
  logic [TIME_W-1:0]  sum_sat;
  logic [TIME_W-1:0]  meas_total;
  logic [TIME_W-1:0]  play_inc;
  logic [BRI_W-1:0]   bri_c;
  logic [LEVEL_W-1:0] level_calc;
  logic [TIME_W-1:0]  wrap_time;

  // percent to drive level, built at elaboration
  logic [LEVEL_W-1:0] level_lut [0:PCT_FULL];
  for (genvar k = 0; k <= PCT_FULL; k++) begin : g_lut
    localparam int LVL = (k * LEVEL_MAX) / PCT_FULL;
    assign level_lut[k] = LEVEL_W'(LVL % 256);
  end

  lbsp_script_mem #(
    .DEPTH(SCRIPT_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (i_cnt[AW-1:0]),
    .rdata (mem_rdata)
  );

  lbsp_scaler u_scaler (
    .clk (clk),
    .rst (rst),
    .req (scl_req),
    .rsp (scl_rsp)
  );

  lbsp_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // incoming beat goes straight into the table on a write
  assign mem_waddr = AW'(req.payload.entry_index);
  assign mem_wdata = '{is_end: req.payload.entry_is_end,
                       bri:    req.payload.entry_brightness,
                       dur:    req.payload.entry_duration};

  // shared helpers for the walk and the sum
  always_comb begin
    i_inc      = i_cnt + CW'(1);
    sum_ext    = {1'b0, t_acc} + (TIME_W + 1)'(scl_rsp.scaled);
    sum_sat    = sum_ext[TIME_W] ? TIME_MAX : sum_ext[TIME_W-1:0];
    meas_total = mem_rdata.is_end ? t_acc : sum_sat;
    play_inc   = (play_time != TIME_MAX) ? play_time + TIME_W'(1) : play_time;
    bri_c      = (mem_rdata.bri > BRI_FULL) ? BRI_FULL : mem_rdata.bri;
    level_calc = analog ? level_lut[bri_c] :
                 ((bri_c != '0) ? LEVEL_LOW : '0);
    wrap_time  = div_rsp.rem + TIME_W'(1);
  end

  always_comb begin
    state_next       = state;
    cmd_q_next       = cmd_q;
    st_q_next        = st_q;
    i_cnt_next       = i_cnt;
    t_acc_next       = t_acc;
    speed_next       = speed;
    loop_en_next     = loop_en;
    analog_next      = analog;
    loaded_next      = loaded;
    play_time_next   = play_time;
    paused_time_next = paused_time;
    total_time_next  = total_time;
    running_next     = running;
    level_next       = level;
    step_next        = step;
    req_ready        = 1'b0;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    scl_req          = '0;
    div_req          = '0;
    load_out         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          cmd_q_next = req.payload.command;
          st_q_next  = req.payload.start_time;
          state_next = ST_DONE;
          unique case (req.payload.command)
            CMD_WRITE: begin
              if (int'(req.payload.entry_index) < SCRIPT_DEPTH) begin
                mem_we      = 1'b1;
                loaded_next = 1'b1;
              end
            end
            CMD_START: begin
              if (loaded) begin
                i_cnt_next = '0;
                t_acc_next = '0;
                state_next = ST_READ;
              end
            end
            CMD_PAUSE: begin
              paused_time_next = play_time;
              running_next     = 1'b0;
            end
            CMD_RESUME: begin
              running_next   = 1'b1;
              play_time_next = paused_time;
            end
            CMD_CLEAR: begin
              paused_time_next = play_time;
              running_next     = 1'b0;
              loaded_next      = 1'b0;
              loop_en_next     = 1'b0;
              level_next       = '0;
            end
            CMD_TICK: begin
              // a tick while stopped or unloaded leaves everything alone
              if (running && loaded) begin
                if (total_time == '0) begin
                  running_next = 1'b0;
                end else if (play_time > total_time) begin
                  if (!loop_en) begin
                    running_next = 1'b0;
                  end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = play_time - TIME_W'(1);
                    div_req.divisor  = total_time;
                    state_next       = ST_MOD;
                  end
                end else begin
                  i_cnt_next = '0;
                  t_acc_next = play_time;
                  state_next = ST_READ;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        mem_re     = 1'b1;
        state_next = ST_GO;
      end

      ST_GO: begin
        scl_req.start    = 1'b1;
        scl_req.duration = mem_rdata.dur;
        scl_req.speed    = speed;
        state_next       = ST_WAIT;
      end

      ST_WAIT: begin
        if (scl_rsp.done) begin
          if (cmd_q == CMD_TICK) begin
            // walk: first entry whose scaled span reaches the remaining time wins
            if (TIME_W'(scl_rsp.scaled) >= t_acc) begin
              level_next     = level_calc;
              step_next      = STEP_W'(i_cnt);
              play_time_next = play_inc;
              state_next     = ST_DONE;
            end else if (mem_rdata.is_end || i_inc == CW'(SCRIPT_DEPTH)) begin
              // ran off the script: keep level and step, time still moves
              play_time_next = play_inc;
              state_next     = ST_DONE;
            end else begin
              t_acc_next = t_acc - TIME_W'(scl_rsp.scaled);
              i_cnt_next = i_inc;
              state_next = ST_READ;
            end
          end else begin
            // measure: sum up to the end mark or the last slot, saturating
            if (mem_rdata.is_end || i_inc == CW'(SCRIPT_DEPTH)) begin
              total_time_next = meas_total;
              running_next    = 1'b1;
              if (meas_total == '0) begin
                play_time_next = st_q;
                state_next     = ST_DONE;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = st_q;
                div_req.divisor  = meas_total;
                state_next       = ST_MOD;
              end
            end else begin
              t_acc_next = sum_sat;
              i_cnt_next = i_inc;
              state_next = ST_READ;
            end
          end
        end
      end

      ST_MOD: begin
        if (div_rsp.done) begin
          if (cmd_q == CMD_TICK) begin
            // wrapped time lands in 1..total, then walk from there
            play_time_next = wrap_time;
            t_acc_next     = wrap_time;
            i_cnt_next     = '0;
            state_next     = ST_READ;
          end else begin
            play_time_next = div_rsp.rem;
            state_next     = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase

    // register writes must only arrive while idle; the block itself does not enforce it
    if (cfg.valid) begin
      unique case (cfg.payload.reg_index)
        REG_SPEED:  speed_next   = cfg.payload.wdata;
        REG_LOOP:   loop_en_next = cfg.payload.wdata[0];
        REG_ANALOG: analog_next  = cfg.payload.wdata[0];
        default: ;
      endcase
    end

    out_valid_next = load_out || (out_valid && !rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      speed       <= SPEED_W'(PCT_FULL);
      loop_en     <= 1'b0;
      analog      <= 1'b1;
      loaded      <= 1'b0;
      play_time   <= '0;
      paused_time <= '0;
      total_time  <= '0;
      running     <= 1'b0;
      level       <= '0;
      step        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      speed       <= speed_next;
      loop_en     <= loop_en_next;
      analog      <= analog_next;
      loaded      <= loaded_next;
      play_time   <= play_time_next;
      paused_time <= paused_time_next;
      total_time  <= total_time_next;
      running     <= running_next;
      level       <= level_next;
      step        <= step_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    cmd_q <= cmd_q_next;
    st_q  <= st_q_next;
    i_cnt <= i_cnt_next;
    t_acc <= t_acc_next;
    if (load_out) begin
      out_q.drive_level <= level;
      out_q.playing     <= running;
      out_q.step_index  <= step;
    end
  end

  assign req.ready   = req_ready;
  assign cfg.ready   = 1'b1;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_q;

endmodule

[rtl/lbsp_script_mem.sv]
module lbsp_script_mem #(
  parameter int DEPTH = lbsp_pkg::SCRIPT_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  lbsp_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output lbsp_pkg::entry_t rdata
);
  import lbsp_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lbsp_scaler.sv]
module lbsp_scaler (
  input  logic                clk,
  input  logic                rst,
  input  lbsp_pkg::scl_req_t  req,
  output lbsp_pkg::scl_rsp_t  rsp
);
  import lbsp_pkg::*;

  logic                        phase;
  logic                        done;
  logic [PROD_W-1:0]           acc;
  logic [SCALED_W-1:0]         res;
  logic [MUL_A_W-1:0]          mul_a;
  logic [MUL_B_W-1:0]          mul_b;
  logic [MUL_A_W+MUL_B_W-1:0]  mul_p;

  // one multiplier: first dur * speed, then (product / 4) * ceil(2^29 / 25)
  always_comb begin
    if (phase) begin
      mul_a = acc[PROD_W-1:2];
      mul_b = MUL_B_W'(RECIP_25);
    end else begin
      mul_a = MUL_A_W'(req.duration);
      mul_b = MUL_B_W'(req.speed);
    end
    mul_p = MUL_A_W'(mul_a) * (MUL_A_W + MUL_B_W)'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (phase) begin
        phase <= 1'b0;
        done  <= 1'b1;
      end else if (req.start) begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!phase && req.start) begin
      acc <= mul_p[PROD_W-1:0];
    end
    if (phase) begin
      res <= mul_p[RECIP_SHIFT+SCALED_W-1:RECIP_SHIFT];
    end
  end

  assign rsp.done   = done;
  assign rsp.scaled = res;

endmodule

[rtl/lbsp_mod.sv]
module lbsp_mod (
  input  logic                clk,
  input  logic                rst,
  input  lbsp_pkg::div_req_t  req,
  output lbsp_pkg::div_rsp_t  rsp
);
  import lbsp_pkg::*;

  localparam int CNT_W = $clog2(TIME_W + 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvd;
  logic [TIME_W-1:0] dsr;
  logic [TIME_W:0]   shifted;
  logic              fits;
  logic [TIME_W-1:0] rem_next;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    shifted  = {rem, dvd[TIME_W-1]};
    fits     = shifted >= {1'b0, dsr};
    rem_next = fits ? TIME_W'(shifted - {1'b0, dsr}) : shifted[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
      cnt <= CNT_W'(TIME_W);
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[TIME_W-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

[tb/led_brightness_script_player_core_tb.sv]
`timescale 1ns / 1ps

module led_brightness_script_player_core_tb;
  import lbsp_pkg::*;

  localparam int DEPTH        = SCRIPT_DEPTH_DEF;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 190;
  localparam int DRAIN_CYCLES = 8;
  localparam int END_CYCLES   = 100;
  localparam int STALL_LIMIT  = 5000;

  // command codes the block has no use for
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  // predicts drive level, playing flag and step for every command beat
  class led_state_predictor;
    entry_t             slots [DEPTH];
    bit                 loaded, running, loop_on, analog_on;
    logic [SPEED_W-1:0] speed;
    logic [TIME_W-1:0]  play_ms, paused_ms, total_ms;
    logic [LEVEL_W-1:0] level;
    logic [STEP_W-1:0]  step;
    rsp_t               expected_states [$];
    int                 mismatches;

    function new();
      foreach (slots[i]) slots[i] = '0;
      loaded     = 1'b0;
      running    = 1'b0;
      loop_on    = 1'b0;
      analog_on  = 1'b1;
      speed      = SPEED_W'(PCT_FULL);
      play_ms    = '0;
      paused_ms  = '0;
      total_ms   = '0;
      level      = '0;
      step       = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_states.size();
    endfunction

    function int unsigned scaled_ms(entry_t e);
      return (32'(e.dur) * 32'(speed)) / PCT_FULL;
    endfunction

    function void set_level(logic [BRI_W-1:0] bri);
      int unsigned pct;
      pct = (bri > BRI_FULL) ? PCT_FULL : bri;
      if (analog_on) level = LEVEL_W'(pct * LEVEL_MAX_DEF / PCT_FULL);
      else level = (pct != 0) ? LEVEL_W'(LEVEL_MAX_DEF) : '0;
    endfunction

    function void sum_script();
      int unsigned acc;
      acc = 0;
      for (int i = 0; i < DEPTH; i++) begin
        if (slots[i].is_end) break;
        acc += scaled_ms(slots[i]);
        if (acc > TIME_MAX) acc = TIME_MAX;
      end
      total_ms = TIME_W'(acc);
    endfunction

    function void tick_ms();
      int unsigned t, rd;
      if (!running || !loaded) return;
      if (total_ms == 0) begin
        running = 1'b0;
        return;
      end
      if (play_ms > total_ms) begin
        if (!loop_on) begin
          running = 1'b0;
          return;
        end
        play_ms = ((play_ms - 1'b1) % total_ms) + 1'b1;
      end
      t = play_ms;
      for (int i = 0; i < DEPTH; i++) begin
        rd = scaled_ms(slots[i]);
        if (rd >= t) begin
          set_level(slots[i].bri);
          step = STEP_W'(i);
          break;
        end
        if (slots[i].is_end) break;
        t -= rd;
      end
      if (play_ms != TIME_MAX) play_ms++;
    endfunction

    function void note_command(req_t c);
      case (c.command)
        CMD_WRITE: begin
          slots[c.entry_index] = {c.entry_is_end, c.entry_brightness, c.entry_duration};
          loaded = 1'b1;
        end
        CMD_START: begin
          if (loaded) begin
            sum_script();
            play_ms = (total_ms != 0) ? c.start_time % total_ms : c.start_time;
            running = 1'b1;
          end
        end
        CMD_PAUSE: begin
          paused_ms = play_ms;
          running   = 1'b0;
        end
        CMD_RESUME: begin
          running = 1'b1;
          play_ms = paused_ms;
        end
        CMD_CLEAR: begin
          paused_ms = play_ms;
          running   = 1'b0;
          loaded    = 1'b0;
          loop_on   = 1'b0;
          level     = '0;
        end
        CMD_TICK: tick_ms();
        default: ;
      endcase
      expected_states.push_back('{drive_level: level, playing: running, step_index: step});
    endfunction

    function void set_register(cfg_t w);
      case (w.reg_index)
        REG_SPEED:  speed = w.wdata;
        REG_LOOP:   loop_on = w.wdata[0];
        REG_ANALOG: analog_on = w.wdata[0];
        default: ;
      endcase
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_states.size() == 0) begin
        mismatches++;
        $error("result beat with no command waiting");
        return;
      end
      want = expected_states.pop_front();
      if (got.drive_level !== want.drive_level)
        report("drive_level", want.drive_level, got.drive_level);
      if (got.playing !== want.playing)
        report("playing", want.playing, got.playing);
      if (got.step_index !== want.step_index)
        report("step_index", want.step_index, got.step_index);
    endfunction
  endclass

  logic clk;
  logic rst;

  lbsp_req_if req_ch ();
  lbsp_rsp_if rsp_ch ();
  lbsp_cfg_if cfg_ch ();

  led_brightness_script_player_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  led_state_predictor model = new();

  int          idle_cycles = 0;
  int          items_sent = 0;
  bit          no_idle = 1'b0;             // burst stretch: neither side idles
  bit          long_stall_pending = 1'b0;  // asks the result side for one long hold-off
  bit [DEPTH-1:0] slot_written = '0;       // slots the stimulus has written so far
  bit [DEPTH-1:0] slot_is_end = '0;        // end marks as last written

  // beats on each channel
  wire cmd_beat = req_ch.valid && req_ch.ready;
  wire rsp_beat = rsp_ch.valid && rsp_ch.ready;
  wire cfg_beat = cfg_ch.valid && cfg_ch.ready;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // predictor and checker both run off the edge at which a beat is taken
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      // note the command first, its result is never taken in the same cycle
      if (cmd_beat) model.note_command(req_ch.payload);
      if (rsp_beat) model.check_result(rsp_ch.payload);
      if (cfg_beat) model.set_register(cfg_ch.payload);
      if (cmd_beat || rsp_beat || cfg_beat) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // nothing moving for too long means the block hung
  initial begin
    @(negedge rst);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  // result side: random hold-off per beat, one long hold when asked
  initial begin
    int hold;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      hold = draw_gap();
      if (long_stall_pending) begin
        long_stall_pending = 1'b0;
        hold = $urandom_range(200, 400);
      end
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid === 1'b1 && !rst));
    end
  end

  // first slot the walk could reach that was never written, -1 if none
  function automatic int first_gap();
    for (int i = 0; i < DEPTH; i++) begin
      if (!slot_written[i]) return i;
      if (slot_is_end[i]) return -1;
    end
    return -1;
  endfunction

  function automatic int short_ms();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(0, 4);
    if (roll < 95) return $urandom_range(0, 40);
    return $urandom_range(0, 65535);
  endfunction

  function automatic int unsigned pick_offset();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return 0;
    if (roll < 60) return $urandom_range(0, 64);
    if (roll < 70) return TIME_MAX;
    return $urandom_range(0, TIME_MAX);
  endfunction

  // command with random filler in the fields it does not use
  function automatic req_t filler(logic [CMD_W-1:0] op);
    req_t c;
    c.command          = op;
    c.entry_index      = IDX_W'($urandom);
    c.entry_duration   = DUR_W'($urandom);
    c.entry_brightness = BRI_W'($urandom);
    c.entry_is_end     = 1'($urandom);
    c.start_time       = TIME_W'($urandom);
    return c;
  endfunction

  // drives one command beat after a random gap
  task automatic issue(req_t c);
    int slot;
    int gap;
    slot = first_gap();
    // a start or tick could walk into an unwritten slot: fill that slot instead
    if ((c.command == CMD_START || c.command == CMD_TICK) && slot >= 0) begin
      c.command        = CMD_WRITE;
      c.entry_index    = IDX_W'(slot);
      c.entry_duration = DUR_W'(short_ms());
    end
    if (c.command == CMD_WRITE) begin
      slot_written[c.entry_index] = 1'b1;
      slot_is_end[c.entry_index]  = c.entry_is_end;
    end
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // valid stays up straight into the next beat when there is no gap
    req_ch.valid   <= 1'b1;
    req_ch.payload <= c;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic put_cmd(logic [CMD_W-1:0] op);
    issue(filler(op));
  endtask

  task automatic put_write(int idx, int dur, int bri, bit is_end);
    req_t c;
    c = filler(CMD_WRITE);
    c.entry_index      = IDX_W'(idx);
    c.entry_duration   = DUR_W'(dur);
    c.entry_brightness = BRI_W'(bri);
    c.entry_is_end     = is_end;
    issue(c);
  endtask

  task automatic put_start(int unsigned offset);
    req_t c;
    c = filler(CMD_START);
    c.start_time = TIME_W'(offset);
    issue(c);
  endtask

  // mostly ticks, with pause/resume pairs and edits to the table mid-play
  task automatic run_ticks(int n);
    int roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        put_cmd(CMD_PAUSE);
        repeat ($urandom_range(0, 3)) put_cmd(CMD_TICK);
        put_cmd(CMD_RESUME);
      end else if (roll < 8) begin
        put_write($urandom_range(0, 7), short_ms(), $urandom_range(0, 127),
                  $urandom_range(0, 3) == 0);
      end else begin
        put_cmd(CMD_TICK);
      end
    end
  endtask

  // block idle: every result in, then a short quiet stretch
  task automatic settle(int cycles);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    int   phase_speed [NUM_PHASES];
    bit   phase_loop [NUM_PHASES];
    bit   phase_analog [NUM_PHASES];
    cfg_t settings [3];
    int   stop_at;
    int   roll;
    int   n_entries;

    phase_speed  = '{100, 1000, 0, 37, 1, 250, 0, 0};
    phase_loop   = '{0, 1, 1, 1, 1, 1, 0, 0};
    phase_analog = '{0, 1, 0, 1, 1, 0, 0, 0};

    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.payload <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part under power-on settings: speed 100, loop off, analog
    // script: 2 ms at full (127 clamps to 100), 0 ms dark, 1 ms full, end mark
    put_write(0, 2, 127, 1'b0);
    put_write(1, 0, 0, 1'b0);
    put_write(2, 1, 100, 1'b0);
    put_write(3, 65535, 1, 1'b1);    // end mark duration is not counted
    put_write(15, 65535, 127, 1'b1); // last slot, past the end mark
    put_cmd(CMD_CLEAR);
    put_start(5);                    // no script loaded: ignored
    put_cmd(CMD_TICK);               // not running: no change
    put_cmd(CMD_RESUME);             // running with nothing loaded
    put_cmd(CMD_TICK);
    put_cmd(CMD_PAUSE);
    put_write(2, 1, 100, 1'b0);      // reloads the table
    put_start(TIME_MAX);             // largest offset, modulo total of 3
    // times 0..3, the boundary picks the earlier entry, then past the end
    repeat (5) put_cmd(CMD_TICK);
    put_cmd(CMD_UNUSED_6);
    put_cmd(CMD_UNUSED_7);
    put_start(0);
    put_cmd(CMD_TICK);
    put_write(0, 0, 0, 1'b1);        // end mark first: zero total
    put_start(12345);                // offset kept as is
    put_cmd(CMD_TICK);               // zero total stops playback

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle(DRAIN_CYCLES);
      if (p >= 6) begin
        phase_speed[p]  = $urandom_range(0, 1000);
        phase_loop[p]   = $urandom_range(0, 1);
        phase_analog[p] = $urandom_range(0, 1);
      end
      settings[0] = '{reg_index: REG_SPEED,  wdata: CFG_DAT_W'(phase_speed[p])};
      settings[1] = '{reg_index: REG_LOOP,   wdata: CFG_DAT_W'(phase_loop[p])};
      settings[2] = '{reg_index: REG_ANALOG, wdata: CFG_DAT_W'(phase_analog[p])};
      foreach (settings[i]) begin
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= settings[i];
        do @(posedge clk); while (!cfg_ch.ready);
      end
      cfg_ch.valid <= 1'b0;

      // in two phases the result side holds off while commands keep coming
      long_stall_pending = (p == 1 || p == 4);
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        no_idle = ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          // fresh short script closed by an end mark, then play it
          n_entries = $urandom_range(1, 6);
          for (int i = 0; i < n_entries; i++)
            put_write(i, short_ms(), $urandom_range(0, 127), 1'b0);
          put_write(n_entries, $urandom_range(0, 65535), $urandom_range(0, 127), 1'b1);
          put_start(pick_offset());
          run_ticks($urandom_range(5, 50));
        end else if (roll < 55) begin
          // replay what is in the table from a new offset
          put_start(pick_offset());
          run_ticks($urandom_range(5, 40));
        end else if (roll < 62) begin
          // whole table with no end mark
          for (int i = 0; i < DEPTH; i++)
            put_write(i, short_ms(), $urandom_range(0, 127), 1'b0);
          put_start(pick_offset());
          run_ticks($urandom_range(10, 60));
        end else if (roll < 67) begin
          // end mark in slot 0: zero total, play time takes the raw offset
          put_write(0, $urandom_range(0, 65535), $urandom_range(0, 127), 1'b1);
          put_start(pick_offset());
          run_ticks($urandom_range(1, 3));
          put_cmd(CMD_PAUSE);
        end else if (roll < 71) begin
          // clear, then resume and tick with no script
          put_cmd(CMD_CLEAR);
          run_ticks($urandom_range(1, 4));
          put_cmd(CMD_RESUME);
          run_ticks($urandom_range(1, 4));
          put_start(pick_offset());
          put_cmd(CMD_TICK);
        end else if (roll < 85) begin
          // pause, maybe restart underneath, then resume the stored time
          put_cmd(CMD_PAUSE);
          run_ticks($urandom_range(0, 3));
          if ($urandom_range(0, 1)) put_start(pick_offset());
          put_cmd(CMD_RESUME);
          run_ticks($urandom_range(3, 20));
        end else begin
          // noise: any code, any field
          repeat ($urandom_range(1, 6)) issue(filler(CMD_W'($urandom_range(0, 7))));
        end
      end
    end

    settle(END_CYCLES);
    if (model.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
